@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle out of reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/rgbf_pkg.sv @@
// Types and constants for the RGB 3x3 window filter
`default_nettype none
package rgbf_pkg;
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned PIX_W = 24;
  localparam int unsigned ROW_W = 12;
  localparam int unsigned COL_W = 11;

  localparam logic [2:0] MODE_BOX   = 3'd0;
  localparam logic [2:0] MODE_GAUSS = 3'd1;
  localparam logic [2:0] MODE_SROW  = 3'd2;
  localparam logic [2:0] MODE_SCOL  = 3'd3;
  localparam logic [2:0] MODE_GREY  = 3'd4;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // classified work for one input pixel
  typedef struct packed {
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [2:0]             mode;
    logic                   do_int;
    logic                   do_pass;
    logic [8:0][PIX_W-1:0]  win;
  } job_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last;
  } res_t;

  function automatic logic [7:0] chan(input logic [PIX_W-1:0] p, input int unsigned k);
    chan = p[8*(2-k) +: 8];
  endfunction
endpackage
`default_nettype wire

@@ rtl/rgbf_front.sv @@
// Front end: line buffers, window, counters and pixel classification
`default_nettype none
module rgbf_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [2:0]         filter_mode,
  input  wire logic [11:0]        frame_width,
  input  wire logic [12:0]        frame_height,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [23:0]        in_pix,
  output logic                    job_valid,
  input  wire logic               job_ready,
  output rgbf_pkg::job_t          job
);
  import rgbf_pkg::*;
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  // stage 1: registered pixel plus position while the buffers are read
  logic              s1_valid;
  logic [23:0]       s1_pix;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic [AW-1:0]     s1_ci;
  logic [2:0]        s1_mode;
  logic              s1_int, s1_pass;
  logic [23:0]       up_q, mid_q;
  logic [23:0]       lb_up  [0:MAX_WIDTH-1];
  logic [23:0]       lb_mid [0:MAX_WIDTH-1];
  logic [23:0]       wcol [0:5];
  logic [WW-1:0]     col_count;
  logic [HW-1:0]     row_count;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic              take, s1_adv, fwd_up, fwd_mid;
  logic [23:0]       up_v, mid_v;
  logic [AW-1:0]     ci;
  logic              lst_col, lst_row;

  always_comb begin
    if (frame_width == 12'd0) w_eff = WW'(1);
    else if ({1'b0, frame_width} > 13'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(frame_width);
    if (frame_height == 13'd0) h_eff = HW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(frame_height);
  end

  assign s1_adv   = !job_valid || job_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign take     = in_valid && in_ready;
  assign ci       = AW'(col_count);
  assign lst_col  = 32'(col_count) + 1 >= 32'(w_eff);
  assign lst_row  = 32'(row_count) + 1 >= 32'(h_eff);

  // a buffer read that hits the entry written by stage 1 this cycle
  assign fwd_up  = s1_valid && s1_ci == ci;
  assign fwd_mid = fwd_up;

  always_ff @(posedge clk) begin
    if (take) begin
      up_q  <= fwd_up ? mid_v : lb_up[ci];
      mid_q <= fwd_mid ? s1_pix : lb_mid[ci];
    end
    if (s1_valid && s1_adv) begin
      lb_up[s1_ci]  <= mid_v;
      lb_mid[s1_ci] <= s1_pix;
    end
  end
  assign up_v  = up_q;
  assign mid_v = mid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      col_count <= '0;
      row_count <= '0;
    end else begin
      if (s1_adv) s1_valid <= take;
      else if (take) s1_valid <= 1'b1;
      if (take) begin
        if (lst_col) begin
          col_count <= '0;
          row_count <= lst_row ? '0 : row_count + 1'b1;
        end else begin
          col_count <= col_count + 1'b1;
        end
      end
    end
    if (take) begin
      s1_pix  <= in_pix;
      s1_col  <= COL_W'(col_count);
      s1_row  <= ROW_W'(row_count);
      s1_ci   <= ci;
      s1_mode <= filter_mode;
      s1_int  <= row_count >= HW'(2) && col_count >= WW'(2) &&
                 32'(row_count) < 32'(h_eff) && 32'(col_count) < 32'(w_eff);
      s1_pass <= row_count == '0 || col_count == '0 || lst_row || lst_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      for (int i = 0; i < 6; i++) wcol[i] <= '0;
    end else if (s1_adv) begin
      job_valid <= s1_valid;
      if (s1_valid) begin
        wcol[0] <= wcol[3];
        wcol[1] <= wcol[4];
        wcol[2] <= wcol[5];
        wcol[3] <= up_v;
        wcol[4] <= mid_v;
        wcol[5] <= s1_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      job.row     <= s1_row;
      job.col     <= s1_col;
      job.mode    <= s1_mode;
      job.do_int  <= s1_int;
      job.do_pass <= s1_pass;
      job.win[0]  <= wcol[0];
      job.win[1]  <= wcol[3];
      job.win[2]  <= up_v;
      job.win[3]  <= wcol[1];
      job.win[4]  <= wcol[4];
      job.win[5]  <= mid_v;
      job.win[6]  <= wcol[2];
      job.win[7]  <= wcol[5];
      job.win[8]  <= s1_pix;
    end
  end
endmodule
`default_nettype wire

@@ rtl/rgbf_queue.sv @@
// Two-entry job queue between front and back end
`default_nettype none
module rgbf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  rgbf_pkg::job_t      wr_job,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output rgbf_pkg::job_t      rd_job
);
  import rgbf_pkg::*;
  job_t        mem [0:1];
  logic        wp, rp;
  logic [1:0]  cnt;
  logic        wr, rd;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
    if (wr) mem[wp] <= wr_job;
  end
endmodule
`default_nettype wire

@@ rtl/rgbf_back.sv @@
// Back end: kernel arithmetic, result sequencing and output register
`default_nettype none
module rgbf_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  rgbf_pkg::job_t   job,
  output logic             res_valid,
  input  wire logic        res_ready,
  output rgbf_pkg::res_t   res
);
  import rgbf_pkg::*;
  // stage A: per-channel sums registered
  logic              a_valid;
  job_t              a_job;
  logic signed [12:0] a_sum [0:2];
  logic [9:0]        a_grey;
  logic              a_second;  // interior already sent, pass pending
  logic              a_ready, a_done;
  logic              out_free;
  logic [7:0]        fv [0:2];
  logic [7:0]        gv;
  res_t              r_next;

  function automatic logic signed [12:0] ksum(input job_t j, input int unsigned k);
    logic signed [12:0] s;
    logic signed [12:0] p [0:8];
    s = '0;
    for (int i = 0; i < 9; i++) p[i] = 13'(chan(j.win[i], k));
    unique case (j.mode)
      MODE_BOX:   s = 13'(p[0]+p[1]+p[2]+p[3]+p[4]+p[5]+p[6]+p[7]+p[8]);
      MODE_GAUSS: s = 13'(p[0]+2*p[1]+p[2]+2*p[3]+4*p[4]+2*p[5]+p[6]+2*p[7]+p[8]);
      MODE_SROW:  s = 13'(p[0]+2*p[1]+p[2]-p[6]-2*p[7]-p[8]);
      MODE_SCOL:  s = 13'(-p[0]+p[2]-2*p[3]+2*p[5]-p[6]+p[8]);
      default:    s = '0;
    endcase
    ksum = s;
  endfunction

  assign out_free  = !res_valid || res_ready;
  assign a_ready   = !a_valid || (out_free && a_done);
  assign job_ready = a_ready;

  always_ff @(posedge clk) begin
    if (job_valid && a_ready) begin
      a_job <= job;
      for (int k = 0; k < 3; k++) a_sum[k] <= ksum(job, k);
      a_grey <= 10'(chan(job.win[8], 0)) + 10'(chan(job.win[8], 1)) +
                10'(chan(job.win[8], 2));
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (a_job.mode)
        MODE_BOX:   fv[k] = 8'((24'(a_sum[k]) * 24'd7282) >> 16);
        MODE_GAUSS: fv[k] = 8'(a_sum[k] >>> 4);
        default:    fv[k] = a_sum[k] < 0 ? 8'd0 : (a_sum[k] > 255 ? 8'd255 : 8'(a_sum[k]));
      endcase
    end
    gv = 8'((24'(a_grey) * 24'd21846) >> 16);
    r_next.row = a_job.row;
    r_next.col = a_job.col;
    r_next.red = chan(a_job.win[8], 0);
    r_next.green = chan(a_job.win[8], 1);
    r_next.blue = chan(a_job.win[8], 2);
    r_next.last = 1'b1;
    a_done = 1'b1;
    if (a_job.mode == MODE_GREY) begin
      r_next.red = gv;
      r_next.green = gv;
      r_next.blue = gv;
    end else if (a_job.mode < MODE_GREY && a_job.do_int && !a_second) begin
      r_next.row = a_job.row - 1'b1;
      r_next.col = a_job.col - 1'b1;
      r_next.red = fv[0];
      r_next.green = fv[1];
      r_next.blue = fv[2];
      r_next.last = !a_job.do_pass;
      a_done = !a_job.do_pass;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_second <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (out_free) res_valid <= 1'b0;
      if (a_valid && out_free) begin
        if (a_job.mode >= MODE_GREY || a_second || a_job.do_int || a_job.do_pass)
          res_valid <= 1'b1;
        a_second <= !a_done;
      end
      if (a_ready) a_valid <= job_valid;
    end
    if (a_valid && out_free) res <= r_next;
  end
endmodule
`default_nettype wire

@@ rtl/rgb_3x3_window_filter.sv @@
// Top level of the RGB 3x3 window filter
// channel | dir | tdata, low bit up                          | tuser/tlast
// s_axis  | in  | red, green, blue (24b)                     | -
// m_axis  | out | row(12), col(11), red, green, blue, pad    | tlast=last_of_run
// cfg     | in  | wr_en, wr_index (2b), wr_data (13b)        | -
// Up to one pixel per clock; a pixel holds the back end for a second result when it
// yields an interior and a border result (last column from the third row on, most of
// the last row). Path: stage 1, front job reg, job queue, stage A, output reg.
// The two-entry job queue lets the front end take pixels in an output stall, until full.
// rst is synchronous and clears counters, window and pipeline valids.
`default_nettype none
`include "assert_macros.svh"
module rgb_3x3_window_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // out_row, out_col, red, green, blue, pad
  output logic             m_axis_tlast,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [12:0] wr_data
);
  import rgbf_pkg::*;
  logic [2:0]  filter_mode;
  logic [11:0] frame_width;
  logic [12:0] frame_height;
  logic        fj_valid, fj_ready, bj_valid, bj_ready;
  job_t        fj, bj;
  res_t        res;
  logic [23:0] pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_BOX;
      frame_width  <= 12'd640;
      frame_height <= 13'd480;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:   filter_mode  <= wr_data[2:0];
        REG_WIDTH:  frame_width  <= wr_data[11:0];
        REG_HEIGHT: frame_height <= wr_data;
        default:    ;
      endcase
    end
  end

  assign pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  rgbf_front u_front (
    .clk, .rst, .filter_mode, .frame_width, .frame_height,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_pix(pix),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  rgbf_queue u_queue (
    .clk, .rst, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
  );

  rgbf_back u_back (
    .clk, .rst, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {1'b0, res.blue, res.green, res.red, res.col, res.row};
  assign m_axis_tlast = res.last;

  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_IMPL(a_q_ovf, clk, rst, fj_valid && !fj_ready, bj_valid)
endmodule
`default_nettype wire
